// ===== sv/jsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    localparam logic [1:0] ST_INSIDE    = 2'd0;
    localparam logic [1:0] ST_CLOSED    = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_OUTSIDE   = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } jsu_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic [1:0] status;
        logic       last;
    } jsu_out_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      nbytes_m1;
        logic            dvalid;
        logic [1:0]      status;
    } jsu_burst_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

    function automatic jsu_burst_t utf8_encode(input logic [20:0] cp);
        jsu_burst_t b;
        b        = '0;
        b.dvalid = 1'b1;
        b.status = ST_INSIDE;
        if (cp <= 21'h7f) begin
            b.bytes[0]  = cp[7:0];
            b.nbytes_m1 = 2'd0;
        end else if (cp <= 21'h7ff) begin
            b.bytes[0]  = {3'b110, cp[10:6]};
            b.bytes[1]  = {2'b10, cp[5:0]};
            b.nbytes_m1 = 2'd1;
        end else if (cp <= 21'hffff) begin
            b.bytes[0]  = {4'b1110, cp[15:12]};
            b.bytes[1]  = {2'b10, cp[11:6]};
            b.bytes[2]  = {2'b10, cp[5:0]};
            b.nbytes_m1 = 2'd2;
        end else begin
            b.bytes[0]  = {5'b11110, cp[20:18]};
            b.bytes[1]  = {2'b10, cp[17:12]};
            b.bytes[2]  = {2'b10, cp[11:6]};
            b.bytes[3]  = {2'b10, cp[5:0]};
            b.nbytes_m1 = 2'd3;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/json_string_unescaper_core.sv =====
// An accepted byte is written into a queue entry, then moved into the output register.
// Throughput: while out_ready is high, one byte per cycle while each byte gives one
// result; a byte that decodes to n UTF-8 bytes holds the output until all n have
// left, one result per cycle, set by the single output register; meanwhile the
// two-entry queue takes the bytes that follow until it fills, then stalls the input.
// Reset: rst_n clears the decoder phase, hex count, unit and surrogate, empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescaper_core (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  jsu_pkg::jsu_in_t   in_data,
    output logic               out_valid,
    input  wire                out_ready,
    output jsu_pkg::jsu_out_t  out_data
);
    import jsu_pkg::*;

    logic       push_valid, push_ready, q_valid, q_pop;
    jsu_burst_t push_data, q_data;

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    jsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== sv/jsu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  jsu_pkg::jsu_in_t    in_data,
    output logic                push_valid,
    input  wire                 push_ready,
    output jsu_pkg::jsu_burst_t push_data
);
    import jsu_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_STR     = 3'd1;
    localparam logic [2:0] PH_ESC     = 3'd2;
    localparam logic [2:0] PH_HEX1    = 3'd3;
    localparam logic [2:0] PH_WANT_BS = 3'd4;
    localparam logic [2:0] PH_WANT_U  = 3'd5;
    localparam logic [2:0] PH_HEX2    = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  hs_reg, hs_next;

    logic [7:0]  c;
    logic [4:0]  hv;
    logic [15:0] unit;
    logic        done;
    logic        accept;
    jsu_burst_t  res;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push_data  = res;
    assign accept     = in_valid && push_ready;

    assign c    = in_data.in_byte;
    assign hv   = hex_value(c);
    assign unit = {acc_reg[11:0], hv[3:0]};
    assign done = (cnt_reg == 2'd3);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        hs_next    = hs_reg;
        res        = '0;
        res.status = ST_INSIDE;
        if (in_data.end_of_input) begin
            if (phase_reg == PH_IDLE || phase_reg > PH_HEX2) begin
                phase_next = PH_IDLE;
                res.status = ST_OUTSIDE;
            end else begin
                phase_next = PH_IDLE;
                cnt_next   = '0;
                acc_next   = '0;
                hs_next    = '0;
                res.status = ST_MALFORMED;
            end
        end else begin
            unique case (phase_reg) inside
                PH_STR:
                begin
                    if (c == 8'h22) begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                        acc_next   = '0;
                        hs_next    = '0;
                        res.status = ST_CLOSED;
                    end else if (c < 8'h20) begin
                        res.status = ST_MALFORMED;
                    end else if (c == 8'h5c) begin
                        phase_next = PH_ESC;
                    end else begin
                        res.bytes[0] = c;
                        res.dvalid   = 1'b1;
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_STR;
                    res.dvalid = 1'b1;
                    unique case (c) inside
                        8'h22, 8'h5c, 8'h2f: res.bytes[0] = c;
                        8'h62:               res.bytes[0] = 8'h08;
                        8'h66:               res.bytes[0] = 8'h0c;
                        8'h6e:               res.bytes[0] = 8'h0a;
                        8'h72:               res.bytes[0] = 8'h0d;
                        8'h74:               res.bytes[0] = 8'h09;
                        8'h75:
                        begin
                            phase_next = PH_HEX1;
                            cnt_next   = '0;
                            acc_next   = '0;
                            res.dvalid = 1'b0;
                        end
                        default:
                        begin
                            res.dvalid = 1'b0;
                            res.status = ST_MALFORMED;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (hv[4]) begin
                        res.status = ST_MALFORMED;
                    end else begin
                        acc_next = unit;
                        cnt_next = cnt_reg + 2'd1;
                        if (done) begin
                            if (phase_reg == PH_HEX1) begin
                                if (unit >= 16'hd800 && unit <= 16'hdbff) begin
                                    hs_next    = unit[9:0];
                                    phase_next = PH_WANT_BS;
                                end else if (unit >= 16'hdc00) begin
                                    if (unit <= 16'hdfff) res.status = ST_MALFORMED;
                                    else begin
                                        phase_next = PH_STR;
                                        res        = utf8_encode({5'd0, unit});
                                    end
                                end else begin
                                    phase_next = PH_STR;
                                    res        = utf8_encode({5'd0, unit});
                                end
                            end else begin
                                if (unit >= 16'hdc00 && unit <= 16'hdfff) begin
                                    phase_next = PH_STR;
                                    res = utf8_encode(21'h10000 + {1'b0, hs_reg, unit[9:0]});
                                end else begin
                                    res.status = ST_MALFORMED;
                                end
                            end
                        end
                    end
                end
                PH_WANT_BS:
                begin
                    if (c == 8'h5c) phase_next = PH_WANT_U;
                    else res.status = ST_MALFORMED;
                end
                PH_WANT_U:
                begin
                    if (c == 8'h75) begin
                        phase_next = PH_HEX2;
                        cnt_next   = '0;
                        acc_next   = '0;
                    end else begin
                        res.status = ST_MALFORMED;
                    end
                end
                default:
                begin
                    if (c == 8'h22) begin
                        phase_next = PH_STR;
                        cnt_next   = '0;
                        acc_next   = '0;
                        hs_next    = '0;
                    end else begin
                        phase_next = PH_IDLE;
                        res.status = ST_OUTSIDE;
                    end
                end
            endcase
            if (res.status == ST_MALFORMED) begin
                phase_next = PH_IDLE;
                cnt_next   = '0;
                acc_next   = '0;
                hs_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            hs_reg    <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            hs_reg    <= hs_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/jsu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  jsu_pkg::jsu_burst_t push_data,
    output logic                pop_valid,
    input  wire                 pop,
    output jsu_pkg::jsu_burst_t pop_data
);
    import jsu_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    jsu_burst_t        mem [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + CW'(1);
        else if (do_pop && !do_push) count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/jsu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_valid,
    output logic                q_pop,
    input  jsu_pkg::jsu_burst_t q_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output jsu_pkg::jsu_out_t   out_data
);
    import jsu_pkg::*;

    logic       out_valid_reg;
    jsu_out_t   out_reg, out_next;
    logic [1:0] idx_reg;
    logic       load, take, at_end;

    assign load      = !out_valid_reg || out_ready;
    assign take      = load && q_valid;
    assign at_end    = (idx_reg == q_data.nbytes_m1);
    assign q_pop     = take && at_end;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        out_next.data_byte  = q_data.bytes[idx_reg];
        out_next.data_valid = q_data.dvalid;
        out_next.status     = q_data.status;
        out_next.last       = at_end;
    end

    always_ff @(posedge clk)
    begin
        if (take) out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (load) out_valid_reg <= q_valid;
            if (take) idx_reg <= at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

`default_nettype wire
